[rtl/core/cfd_pkg.sv]
package cfd_pkg;

    localparam int CHANNELS = 7;
    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int BYTE_W = 8;
    localparam int CH_OUT_W = 3;
    localparam int VALUE_W = 16;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    localparam logic [BYTE_W-1:0] START_BYTE = 8'h80;
    localparam logic [BYTE_W-1:0] END_BYTE = 8'hC0;

    typedef enum logic [2:0] {
        ST_HUNT1,
        ST_HUNT2,
        ST_LOW,
        ST_HIGH,
        ST_END1,
        ST_END2,
        ST_EMIT
    } cfd_state_t;

    typedef struct packed {
        logic load_low;
        logic store_word;
        logic idx_clr;
        logic end_capture;
        logic end_clear;
        logic emit_load;
    } cfd_cmd_t;

    typedef struct packed {
        logic byte_start;
        logic byte_end;
        logic pair_restart;
        logic idx_last;
        logic end_ok;
        logic emit_last;
        logic out_free;
    } cfd_sts_t;

endpackage

[rtl/core/cfd_datapath.sv]
module cfd_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [cfd_pkg::BYTE_W-1:0]          rx_byte,
    input  cfd_pkg::cfd_cmd_t                   cmd,
    output cfd_pkg::cfd_sts_t                   sts,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [cfd_pkg::CH_OUT_W-1:0]        out_channel,
    output logic [cfd_pkg::VALUE_W-1:0]         out_value,
    output logic                                out_last
);
    import cfd_pkg::*;

    logic [BYTE_W-1:0]  low_byte_reg, low_byte_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               end_ok_reg, end_ok_next;
    logic [IDX_W-1:0]   emit_idx_reg, emit_idx_next;
    logic               valid_reg, valid_next;
    logic [CH_OUT_W-1:0] ch_reg, ch_next;
    logic [VALUE_W-1:0] val_reg;
    logic               last_reg, last_next;
    logic [VALUE_W-1:0] store_reg [CHANNELS];

    always_comb begin
        sts.byte_start   = (rx_byte == START_BYTE);
        sts.byte_end     = (rx_byte == END_BYTE);
        sts.pair_restart = ((low_byte_reg == START_BYTE) && (rx_byte == START_BYTE)) ||
                           ((low_byte_reg == END_BYTE) && (rx_byte == END_BYTE));
        sts.idx_last     = (idx_reg == IDX_W'(CHANNELS - 1));
        sts.end_ok       = end_ok_reg;
        sts.emit_last    = (emit_idx_reg == IDX_W'(CHANNELS - 1));
        sts.out_free     = !valid_reg || out_ready;
    end

    always_comb begin
        low_byte_next = cmd.load_low ? rx_byte : low_byte_reg;

        idx_next = idx_reg;
        if (cmd.idx_clr) begin
            idx_next = '0;
        end else if (cmd.store_word) begin
            idx_next = sts.idx_last ? '0 : idx_reg + IDX_W'(1);
        end

        end_ok_next = end_ok_reg;
        if (cmd.end_clear) begin
            end_ok_next = 1'b0;
        end else if (cmd.end_capture) begin
            end_ok_next = sts.byte_end;
        end

        emit_idx_next = emit_idx_reg;
        valid_next    = valid_reg;
        ch_next       = ch_reg;
        last_next     = last_reg;
        if (cmd.emit_load) begin
            emit_idx_next = sts.emit_last ? '0 : emit_idx_reg + IDX_W'(1);
            valid_next    = 1'b1;
            ch_next       = CH_OUT_W'(emit_idx_reg);
            last_next     = sts.emit_last;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_byte_reg <= '0;
            idx_reg      <= '0;
            end_ok_reg   <= 1'b0;
            emit_idx_reg <= '0;
            valid_reg    <= 1'b0;
        end else begin
            low_byte_reg <= low_byte_next;
            idx_reg      <= idx_next;
            end_ok_reg   <= end_ok_next;
            emit_idx_reg <= emit_idx_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ch_reg   <= ch_next;
        last_reg <= last_next;
        if (cmd.emit_load) begin
            val_reg <= store_reg[emit_idx_reg];
        end
        if (cmd.store_word) begin
            store_reg[idx_reg] <= {rx_byte, low_byte_reg};
        end
    end

    assign out_valid   = valid_reg;
    assign out_channel = ch_reg;
    assign out_value   = val_reg;
    assign out_last    = last_reg;

endmodule

[rtl/core/cfd_ctrl.sv]
module cfd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  cfd_pkg::cfd_sts_t  sts,
    output cfd_pkg::cfd_cmd_t  cmd
);
    import cfd_pkg::*;

    cfd_state_t state_reg, state_next;
    logic       fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HUNT1;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = (state_reg != ST_EMIT);
        fire       = in_valid && in_ready;
        case (state_reg)
            ST_HUNT1: begin
                if (fire && sts.byte_start) begin
                    state_next = ST_HUNT2;
                end
            end
            ST_HUNT2: begin
                if (fire) begin
                    if (sts.byte_start) begin
                        cmd.idx_clr = 1'b1;
                        state_next  = ST_LOW;
                    end else begin
                        state_next = ST_HUNT1;
                    end
                end
            end
            ST_LOW: begin
                if (fire) begin
                    cmd.load_low = 1'b1;
                    state_next   = ST_HIGH;
                end
            end
            ST_HIGH: begin
                if (fire) begin
                    if (sts.pair_restart) begin
                        cmd.idx_clr = 1'b1;
                        state_next  = ST_LOW;
                    end else begin
                        cmd.store_word = 1'b1;
                        state_next     = sts.idx_last ? ST_END1 : ST_LOW;
                    end
                end
            end
            ST_END1: begin
                if (fire) begin
                    cmd.end_capture = 1'b1;
                    state_next      = ST_END2;
                end
            end
            ST_END2: begin
                if (fire) begin
                    cmd.end_clear = 1'b1;
                    state_next    = (sts.end_ok && sts.byte_end) ? ST_EMIT : ST_HUNT1;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit_load = 1'b1;
                    if (sts.emit_last) begin
                        state_next = ST_HUNT1;
                    end
                end
            end
            default: begin
                state_next = ST_HUNT1;
            end
        endcase
    end

endmodule

[rtl/core/channel_frame_deframer_core.sv]
// Serial frame deframer. Takes one received byte per word on the s_ channel,
// hunts for the 0x80 0x80 start marker, gathers CHANNELS little-endian 16-bit
// values and checks the 0xC0 0xC0 end marker. A good frame is replayed on the
// m_ channel as CHANNELS words in channel order, tlast on the final one; a bad
// frame produces nothing. Bytes are taken at one per cycle while deframing.
// After a committed frame, s_tready stays low while the stored values are
// read out one per cycle through the output register, unless m_tready holds
// the output back.
module channel_frame_deframer_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cfd_pkg::S_TDATA_W-1:0]     s_tdata,   // [7:0] rx_byte
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cfd_pkg::M_TDATA_W-1:0]     m_tdata,   // [2:0] channel, [18:3] value, zero pad
    output logic                              m_tlast
);
    import cfd_pkg::*;

    cfd_cmd_t              cmd;
    cfd_sts_t              sts;
    logic [CH_OUT_W-1:0]   out_channel;
    logic [VALUE_W-1:0]    out_value;

    cfd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cfd_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .rx_byte     (s_tdata[BYTE_W-1:0]),
        .cmd         (cmd),
        .sts         (sts),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_channel (out_channel),
        .out_value   (out_value),
        .out_last    (m_tlast)
    );

    assign m_tdata = {(M_TDATA_W - VALUE_W - CH_OUT_W)'(0), out_value, out_channel};

endmodule

[rtl/core/cfd_checker.sv]
module cfd_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [cfd_pkg::M_TDATA_W-1:0]     m_tdata,
    input logic                              m_tlast
);
    import cfd_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("output word changed while stalled");

    a_emit_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> !s_tready)
        else $error("input taken during frame readout");

    a_last_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[CH_OUT_W-1:0] == CH_OUT_W'(CHANNELS - 1)))
        else $error("tlast on wrong channel");

    a_readout_gapless: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("gap inside frame readout");

    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=>
            (!m_tvalid || (m_tdata[CH_OUT_W-1:0] == '0)))
        else $error("frame after frame end does not start at channel 0");

endmodule

bind channel_frame_deframer_core cfd_checker u_cfd_checker (.*);
